FILE: hdl/dsp_pkg.sv
// Shared constants, command codes and controller/datapath structs
// for the deadline shortest path block. No dependencies.
package dsp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;
  localparam int TIME_BITS_DEF    = 48;

  localparam int VERTEX_W  = 6;
  localparam int LENGTH_W  = 32;
  localparam int CMD_W     = 2;
  localparam int COUNT_W   = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

  localparam logic [CMD_W-1:0] CMD_DEADLINE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic idle;
    logic run_init;
    logic scan_init;
    logic scan;
    logic pick;
    logic edge_rd;
    logic edge_tg;
    logic edge_upd;
    logic emit_init;
    logic emit_rd;
    logic emit_ld;
    logic emit_wait;
  } dsp_cmd_t;

  typedef struct packed {
    logic run_req;
    logic scan_done;
    logic found;
    logic edge_any;
    logic edge_last;
    logic out_taken;
    logic emit_last;
  } dsp_stat_t;

endpackage

FILE: hdl/dsp_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on dsp_pkg.
interface dsp_in_if import dsp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [VERTEX_W-1:0]  vertex;
  logic [TIME_BITS-1:0] deadline;
  logic [VERTEX_W-1:0]  edge_end_a;
  logic [VERTEX_W-1:0]  edge_end_b;
  logic [LENGTH_W-1:0]  edge_length;

  modport source (output valid, cmd, vertex, deadline, edge_end_a, edge_end_b, edge_length,
                  input ready);
  modport sink (input valid, cmd, vertex, deadline, edge_end_a, edge_end_b, edge_length,
                output ready);
endinterface

interface dsp_out_if import dsp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [VERTEX_W-1:0]       out_vertex;
  logic signed [TIME_BITS:0] arrival_time;
  logic                      last;
  logic                      edges_dropped;

  modport source (output valid, out_vertex, arrival_time, last, edges_dropped, input ready);
  modport sink (input valid, out_vertex, arrival_time, last, edges_dropped, output ready);
endinterface

FILE: hdl/deadline_shortest_path.sv
// Top level of the deadline shortest path block: APB register, controller
// and datapath. Depends on dsp_pkg, dsp_if, dsp_ctrl, dsp_dp.
//
//   channel   dir  handshake      word
//   items     in   valid/ready    cmd, vertex, deadline, edge ends, length
//   results   out  valid/ready    out_vertex, arrival_time, last, edges_dropped
//   apb       in   psel/penable   vertex_count at address 0
//
// Load items (deadline, edge, clear) are accepted while the block is idle.
// A run repeats, for each reached vertex, a scan of the arrival store over the n
// vertices in use and a walk of the E stored edges through the single read port,
// then emits one result per vertex in use; output stalls lengthen it.
// Reset is synchronous; deadline and arrival stores read as cleared via valid bits.
// Items are held off (ready low) from the run until its last result is taken.
module deadline_shortest_path import dsp_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  dsp_in_if.sink             items,
  dsp_out_if.source          results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [COUNT_W-1:0] vertex_count;
  logic [NW-1:0]      n;
  logic               reg_hit;
  dsp_cmd_t           cmd;
  dsp_stat_t          stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? PDATA_W'(vertex_count) : '0;

  always_comb begin
    if (vertex_count == '0) begin
      n = NW'(1);
    end else if (vertex_count > COUNT_W'(MAX_VERTICES)) begin
      n = NW'(MAX_VERTICES);
    end else begin
      n = NW'(vertex_count);
    end
  end

  dsp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  dsp_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .TIME_BITS    (TIME_BITS),
    .NW           (NW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .n       (n),
    .cmd     (cmd),
    .stat    (stat),
    .items   (items),
    .results (results)
  );
endmodule

FILE: hdl/dsp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/dsp_ctrl.sv
// Run sequencer: scan for the next vertex, walk the edges, emit results.
// Depends on dsp_pkg.
module dsp_ctrl import dsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dsp_stat_t stat,
  output dsp_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INIT      = 4'd1;
  localparam logic [3:0] S_SCAN0     = 4'd2;
  localparam logic [3:0] S_SCAN      = 4'd3;
  localparam logic [3:0] S_PICK      = 4'd4;
  localparam logic [3:0] S_ERD       = 4'd5;
  localparam logic [3:0] S_ETG       = 4'd6;
  localparam logic [3:0] S_EUPD      = 4'd7;
  localparam logic [3:0] S_EMIT_INIT = 4'd8;
  localparam logic [3:0] S_EMIT_RD   = 4'd9;
  localparam logic [3:0] S_EMIT_LD   = 4'd10;
  localparam logic [3:0] S_EMIT_WAIT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (stat.run_req) state_next = S_INIT;
      S_INIT:      state_next = S_SCAN0;
      S_SCAN0:     state_next = S_SCAN;
      S_SCAN:      if (stat.scan_done) state_next = stat.found ? S_PICK : S_EMIT_INIT;
      S_PICK:      state_next = stat.edge_any ? S_ERD : S_SCAN0;
      S_ERD:       state_next = S_ETG;
      S_ETG:       state_next = S_EUPD;
      S_EUPD:      state_next = stat.edge_last ? S_SCAN0 : S_ERD;
      S_EMIT_INIT: state_next = S_EMIT_RD;
      S_EMIT_RD:   state_next = S_EMIT_LD;
      S_EMIT_LD:   state_next = S_EMIT_WAIT;
      S_EMIT_WAIT: if (stat.out_taken) state_next = stat.emit_last ? S_IDLE : S_EMIT_RD;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.idle      = (state == S_IDLE);
    cmd.run_init  = (state == S_INIT);
    cmd.scan_init = (state == S_SCAN0);
    cmd.scan      = (state == S_SCAN);
    cmd.pick      = (state == S_PICK);
    cmd.edge_rd   = (state == S_ERD);
    cmd.edge_tg   = (state == S_ETG);
    cmd.edge_upd  = (state == S_EUPD);
    cmd.emit_init = (state == S_EMIT_INIT);
    cmd.emit_rd   = (state == S_EMIT_RD);
    cmd.emit_ld   = (state == S_EMIT_LD);
    cmd.emit_wait = (state == S_EMIT_WAIT);
  end
endmodule

FILE: hdl/dsp_dp.sv
// Datapath: deadline, edge and arrival time stores, scan and relax logic,
// result register. Depends on dsp_pkg, dsp_if, dsp_ram.
module dsp_dp import dsp_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [NW-1:0] n,
  input  dsp_cmd_t      cmd,
  output dsp_stat_t     stat,
  dsp_in_if.sink        items,
  dsp_out_if.source     results
);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * VERTEX_W + LENGTH_W;

  logic                    acc;
  logic [MAX_VERTICES-1:0] settled;
  logic [MAX_VERTICES-1:0] dl_valid;
  logic [MAX_VERTICES-1:0] bt_valid;
  logic                    overflow;
  logic [ECW-1:0]          edge_count;
  logic [EAW-1:0]          eidx;
  logic [NW-1:0]           vidx;
  logic [VAW-1:0]          cidx;
  logic [VAW-1:0]          pick;
  logic [VAW-1:0]          tgt;
  logic                    pend;
  logic                    found;
  logic [TIME_BITS-1:0]    min_time;
  logic [LENGTH_W-1:0]     len_r;
  logic                    rel_ok;
  logic                    bt_rv;
  logic                    st_rv;
  logic                    dl_rv;

  logic                    dl_we;
  logic [TIME_BITS-1:0]    dl_rd;
  logic                    e_we;
  logic [EW-1:0]           e_rd;
  logic                    bt_we;
  logic [VAW-1:0]          bt_waddr;
  logic [TIME_BITS-1:0]    bt_wdata;
  logic [VAW-1:0]          bt_raddr;
  logic [TIME_BITS-1:0]    bt_rd;

  logic [VERTEX_W-1:0]     e_a;
  logic [VERTEX_W-1:0]     e_b;
  logic                    a_hit;
  logic                    b_hit;
  logic                    ends_in;
  logic [VERTEX_W-1:0]     e_other;
  logic [VAW-1:0]          e_target;
  logic [TIME_BITS:0]      t_new;
  logic                    upd_ok;
  logic                    out_valid;

  assign acc         = items.valid & cmd.idle;
  assign items.ready = cmd.idle;

  assign dl_we = acc && (items.cmd == CMD_DEADLINE) &&
                 ((COUNT_W + 1)'(items.vertex) < (COUNT_W + 1)'(MAX_VERTICES));
  assign e_we  = acc && (items.cmd == CMD_EDGE) && (edge_count < ECW'(MAX_EDGES));

  assign e_a      = e_rd[EW-1 -: VERTEX_W];
  assign e_b      = e_rd[LENGTH_W +: VERTEX_W];
  assign a_hit    = (e_a == VERTEX_W'(pick));
  assign b_hit    = (e_b == VERTEX_W'(pick));
  assign ends_in  = (COUNT_W'(e_a) < COUNT_W'(n)) && (COUNT_W'(e_b) < COUNT_W'(n));
  assign e_other  = a_hit ? e_b : e_a;
  assign e_target = e_other[VAW-1:0];

  assign t_new  = {1'b0, min_time} + (TIME_BITS + 1)'(len_r);
  assign upd_ok = rel_ok && dl_rv && (t_new < {1'b0, dl_rd}) &&
                  (!bt_rv || (t_new < {1'b0, bt_rd}));

  assign bt_we    = cmd.run_init || (cmd.edge_upd && upd_ok);
  assign bt_waddr = cmd.run_init ? '0 : tgt;
  assign bt_wdata = cmd.run_init ? '0 : t_new[TIME_BITS-1:0];
  assign bt_raddr = cmd.edge_tg ? e_target : vidx[VAW-1:0];

  dsp_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_VERTICES)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (items.vertex[VAW-1:0]),
    .wdata (items.deadline),
    .raddr (e_target),
    .rdata (dl_rd)
  );

  dsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (edge_count[EAW-1:0]),
    .wdata ({items.edge_end_a, items.edge_end_b, items.edge_length}),
    .raddr (eidx),
    .rdata (e_rd)
  );

  dsp_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_VERTICES)) u_bt_ram (
    .clk   (clk),
    .we    (bt_we),
    .waddr (bt_waddr),
    .wdata (bt_wdata),
    .raddr (bt_raddr),
    .rdata (bt_rd)
  );

  always_ff @(posedge clk) begin
    bt_rv <= bt_valid[bt_raddr];
    st_rv <= settled[bt_raddr];
    dl_rv <= dl_valid[e_target];
    if (cmd.edge_tg) begin
      tgt    <= e_target;
      len_r  <= e_rd[LENGTH_W-1:0];
      rel_ok <= (a_hit || b_hit) && ends_in && !settled[e_target];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid   <= '0;
      edge_count <= '0;
      overflow   <= 1'b0;
    end else begin
      if (dl_we) begin
        dl_valid[items.vertex[VAW-1:0]] <= 1'b1;
      end
      if (e_we) begin
        edge_count <= edge_count + ECW'(1);
      end else if (acc && (items.cmd == CMD_EDGE)) begin
        overflow <= 1'b1;
      end
      if (acc && (items.cmd == CMD_CLEAR)) begin
        edge_count <= '0;
        overflow   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settled  <= '0;
      bt_valid <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      vidx     <= '0;
      eidx     <= '0;
    end else begin
      if (cmd.run_init) begin
        settled  <= '0;
        bt_valid <= MAX_VERTICES'(1);
      end
      if (cmd.edge_upd && upd_ok) begin
        bt_valid[tgt] <= 1'b1;
      end
      if (cmd.scan_init || cmd.emit_init) begin
        vidx  <= '0;
        pend  <= 1'b0;
        found <= 1'b0;
      end
      if (cmd.scan) begin
        if (vidx < n) begin
          vidx <= vidx + NW'(1);
          cidx <= vidx[VAW-1:0];
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (pend && !st_rv && bt_rv && (!found || (bt_rd < min_time))) begin
          found    <= 1'b1;
          min_time <= bt_rd;
          pick     <= cidx;
        end
      end
      if (cmd.pick) begin
        settled[pick] <= 1'b1;
        eidx          <= '0;
      end
      if (cmd.edge_upd) begin
        eidx <= eidx + EAW'(1);
      end
      if (cmd.emit_wait && stat.out_taken) begin
        vidx <= vidx + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (stat.out_taken) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      results.out_vertex    <= VERTEX_W'(vidx);
      results.arrival_time  <= bt_rv ? $signed({1'b0, bt_rd}) : '1;
      results.last          <= stat.emit_last;
      results.edges_dropped <= overflow;
    end
  end

  assign results.valid = out_valid;

  always_comb begin
    stat           = '0;
    stat.run_req   = acc && (items.cmd == CMD_RUN);
    stat.scan_done = (vidx == n) && !pend;
    stat.found     = found;
    stat.edge_any  = (edge_count != '0);
    stat.edge_last = ((ECW'(eidx) + ECW'(1)) == edge_count);
    stat.out_taken = out_valid && results.ready;
    stat.emit_last = ((vidx + NW'(1)) == n);
  end
endmodule

FILE: sim/tb_deadline_shortest_path.sv
// Testbench for deadline_shortest_path: drives load and run items and APB
// writes of vertex_count, predicts arrival times and checks every result word.
// Depends on dsp_pkg, dsp_if and the RTL of the block.
module tb_deadline_shortest_path;
  import dsp_pkg::*;

  typedef struct packed {
    logic [5:0]  vtx;
    logic [48:0] arr;
    logic        lst;
    logic        drop;
  } result_word_t;

  class path_scoreboard;
    logic [47:0]  deadline_mem [64];
    logic [5:0]   edge_a [256];
    logic [5:0]   edge_b [256];
    logic [31:0]  edge_len [256];
    int           n_edges;
    bit           dropped;
    int           n_used;
    result_word_t pending[$];
    int           errors;

    function void clear_all();
      foreach (deadline_mem[i]) deadline_mem[i] = '0;
      n_edges = 0;
      dropped = 0;
      n_used = 64;
      errors = 0;
      pending.delete();
    endfunction

    function void set_count(logic [6:0] v);
      n_used = (v == 0) ? 1 : (v > 64 ? 64 : v);
    endfunction

    function void note_item(logic [1:0] cmd, logic [5:0] vx, logic [47:0] dl,
                            logic [5:0] ea, logic [5:0] eb, logic [31:0] len);
      longint       best [64];
      bit           done [64];
      int           pick;
      logic [63:0]  t;
      int           o;
      result_word_t w;
      case (cmd)
        CMD_DEADLINE: deadline_mem[vx] = dl;
        CMD_EDGE: begin
          if (n_edges >= 256) begin
            dropped = 1;
          end else begin
            edge_a[n_edges] = ea;
            edge_b[n_edges] = eb;
            edge_len[n_edges] = len;
            n_edges++;
          end
        end
        CMD_CLEAR: begin
          n_edges = 0;
          dropped = 0;
        end
        default: begin
          for (int v = 0; v < 64; v++) begin
            best[v] = -1;
            done[v] = 0;
          end
          best[0] = 0;
          forever begin
            pick = -1;
            for (int v = 0; v < n_used; v++)
              if (!done[v] && best[v] >= 0 && (pick < 0 || best[v] < best[pick])) pick = v;
            if (pick < 0) break;
            done[pick] = 1;
            for (int e = 0; e < n_edges; e++) begin
              if (edge_a[e] >= n_used || edge_b[e] >= n_used) continue;
              for (int s = 0; s < 2; s++) begin
                if ((s == 0 ? edge_a[e] : edge_b[e]) != pick) continue;
                o = (s == 0) ? edge_b[e] : edge_a[e];
                if (done[o]) continue;
                t = best[pick] + edge_len[e];
                if (t < {16'd0, deadline_mem[o]} && (best[o] < 0 || t < best[o]))
                  best[o] = t;
              end
            end
          end
          for (int v = 0; v < n_used; v++) begin
            w.vtx = 6'(v);
            w.arr = best[v][48:0];
            w.lst = (v + 1 == n_used);
            w.drop = dropped;
            pending.push_back(w);
          end
        end
      endcase
    endfunction

    function void check_word(result_word_t got);
      result_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result vertex %0d time %0d", $time, got.vtx, got.arr);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch expected v=%0d t=%0h last=%0b drop=%0b, got v=%0d t=%0h last=%0b drop=%0b",
                 $time, exp_w.vtx, exp_w.arr, exp_w.lst, exp_w.drop,
                 got.vtx, got.arr, got.lst, got.drop);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dsp_in_if  items();
  dsp_out_if results();

  deadline_shortest_path u_top (
    .clk(clk), .rst(rst), .items(items.sink), .results(results.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  path_scoreboard board = new();
  bit quiet = 0;
  bit hold_long = 0;
  int ok_flag;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    items.valid = 0;
    items.cmd = '0;
    items.vertex = '0;
    items.deadline = '0;
    items.edge_end_a = '0;
    items.edge_end_b = '0;
    items.edge_length = '0;
    results.ready = 0;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        results.ready <= 0;
        repeat (400) @(posedge clk);
        hold_long = 0;
        results.ready <= 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        results.ready <= 0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        results.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    result_word_t w;
    if (!rst && results.valid && results.ready) begin
      w.vtx = results.out_vertex;
      w.arr = results.arrival_time;
      w.lst = results.last;
      w.drop = results.edges_dropped;
      board.check_word(w);
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [5:0] vx, logic [47:0] dl,
                           logic [5:0] ea, logic [5:0] eb, logic [31:0] len);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      items.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    items.valid <= 1;
    items.cmd <= cmd;
    items.vertex <= vx;
    items.deadline <= dl;
    items.edge_end_a <= ea;
    items.edge_end_b <= eb;
    items.edge_length <= len;
    do @(posedge clk); while (!items.ready);
    board.note_item(cmd, vx, dl, ea, eb, len);
  endtask

  task automatic drain();
    items.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {REG_VERTEX_COUNT, 2'b00};
    pwdata <= {25'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.set_count(v);
  endtask

  function automatic logic [47:0] rand_deadline(int spread);
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(1, spread));
    endcase
  endfunction

  function automatic logic [31:0] rand_len(int spread);
    case ($urandom_range(0, 7))
      0: return '1;
      1: return 0;
      2: return $urandom;
      default: return $urandom_range(1, spread);
    endcase
  endfunction

  task automatic random_graph(int nv, int ne, int spread);
    for (int i = 0; i < nv; i++)
      send_item(CMD_DEADLINE, 6'($urandom_range(0, 63)), rand_deadline(spread * 4), 0, 0, 0);
    for (int i = 0; i < ne; i++)
      send_item(CMD_EDGE, 0, 0, 6'($urandom_range(0, nv)), 6'($urandom_range(0, nv)),
                rand_len(spread));
  endtask

  initial begin
    board.clear_all();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: all deadlines zero, run at reset count
    send_item(CMD_RUN, 0, 0, 0, 0, 0);
    drain();
    write_count(7'd4);
    send_item(CMD_DEADLINE, 0, 48'd0, 0, 0, 0);
    send_item(CMD_DEADLINE, 1, 48'd10, 0, 0, 0);
    send_item(CMD_DEADLINE, 2, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
    send_item(CMD_DEADLINE, 3, 48'd6, 0, 0, 0);
    send_item(CMD_DEADLINE, 63, 48'hAAAA_5555_AAAA, 0, 0, 0);
    send_item(CMD_EDGE, 0, 0, 0, 1, 32'd10);
    send_item(CMD_EDGE, 0, 0, 1, 0, 32'd9);
    send_item(CMD_EDGE, 0, 0, 2, 2, 32'd0);
    send_item(CMD_EDGE, 0, 0, 0, 3, 32'd5);
    send_item(CMD_EDGE, 0, 0, 3, 2, 32'hFFFF_FFFF);
    send_item(CMD_EDGE, 0, 0, 63, 0, 32'd1);
    send_item(CMD_EDGE, 0, 0, 6'h2A, 6'h15, 32'h5555_AAAA);
    send_item(CMD_RUN, 0, 0, 0, 0, 0);
    drain();
    write_count(7'd0);
    send_item(CMD_RUN, 0, 0, 0, 0, 0);
    drain();
    write_count(7'd127);
    send_item(CMD_RUN, 0, 0, 0, 0, 0);
    drain();
    write_count(7'd1);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
    send_item(CMD_RUN, 0, 0, 0, 0, 0);
    drain();

    // overflow of the edge store, long receiver hold-off
    write_count(7'd8);
    for (int i = 0; i < 260; i++)
      send_item(CMD_EDGE, 0, 0, 6'($urandom_range(0, 9)), 6'($urandom_range(0, 9)),
                rand_len(50));
    hold_long = 1;
    send_item(CMD_RUN, 0, 0, 0, 0, 0);
    send_item(CMD_DEADLINE, 5, 48'd99, 0, 0, 0);
    send_item(CMD_RUN, 0, 0, 0, 0, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 2) quiet = 1;
      write_count($urandom_range(0, 3) == 0 ? 7'($urandom_range(0, 127)) :
                  7'($urandom_range(2, 12)));
      if ($urandom_range(0, 1)) send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
      for (int i = 0; i < 1; i++) begin
        random_graph($urandom_range(2, 8), $urandom_range(3, 8), 40);
        if ($urandom_range(0, 3) == 0) send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_item(CMD_RUN, 0, 0, 0, 0, 0);
      end
      drain();
    end

    ok_flag = (board.errors == 0) && (board.pending.size() == 0);
    if (ok_flag) begin
      $display("tb_deadline_shortest_path passed");
    end else begin
      $display("tb_deadline_shortest_path failed");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("tb_deadline_shortest_path failed");
    $finish;
  end
endmodule
